@@ design/hea_pkg.sv @@
// ============================================================================
// hea_pkg
// Shared types, constants and fixed-point helpers for the Hubbard energy
// accumulator: command word layout, sequencer states and saturating math.
// ============================================================================
package hea_pkg;

  // Lattice size and input value width
  localparam int MAX_SITES  = 16;
  localparam int VALUE_BITS = 32;

  // Fixed-point formats: inputs Q8.24, sums Q24.40
  localparam int DATA_W       = 32;
  localparam int ACC_W        = 64;
  localparam int FRAC_BITS    = 24;
  localparam int PROD_SHIFT   = 8;
  localparam int WEIGHT_SHIFT = 16;
  localparam int MUL_W        = DATA_W + 1;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int WIDE_W       = PROD_W + DATA_W;

  // Index and store geometry
  localparam int DIM        = 2 * MAX_SITES;
  localparam int HOP_DEPTH  = DIM * DIM;
  localparam int HOP_AW     = (HOP_DEPTH > 1) ? $clog2(HOP_DEPTH) : 1;
  localparam int SITE_AW    = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int PART_AW    = SITE_AW + 2;
  localparam int PART_DEPTH = 1 << PART_AW;
  localparam int SITE_W     = 5 * DATA_W;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  // Opcodes
  localparam logic [2:0] OP_LOAD_HOP  = 3'd0;
  localparam logic [2:0] OP_LOAD_SITE = 3'd1;
  localparam logic [2:0] OP_GREEN     = 3'd2;
  localparam logic [2:0] OP_FINISH    = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  // Partial slots of a site: up-up, down-down, up-down, down-up
  localparam logic [1:0] SLOT_UU = 2'd0;
  localparam logic [1:0] SLOT_DD = 2'd1;
  localparam logic [1:0] SLOT_UD = 2'd2;
  localparam logic [1:0] SLOT_DU = 2'd3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_HOP,
    CMD_SITE,
    CMD_GREEN,
    CMD_FINISH,
    CMD_CLEAR
  } cmd_kind_t;

  // Classified word handed from front to back
  typedef struct packed {
    cmd_kind_t                kind;
    logic [HOP_AW-1:0]        hop_addr;
    logic [SITE_AW-1:0]       site;
    logic [1:0]               slot;
    logic                     local_hit;
    logic signed [DATA_W-1:0] value_re;
    logic signed [DATA_W-1:0] value_im;
    logic signed [DATA_W-1:0] onsite_u;
    logic signed [DATA_W-1:0] chem_pot;
    logic signed [DATA_W-1:0] field_x;
    logic signed [DATA_W-1:0] field_y;
    logic signed [DATA_W-1:0] field_z;
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_G_READ,
    ST_G_KIN,
    ST_G_KACC,
    ST_G_LACC,
    ST_G_PSAT,
    ST_G_U,
    ST_G_IACC,
    ST_F_H1,
    ST_F_H2,
    ST_F_LO,
    ST_F_HI,
    ST_F_COMB,
    ST_F_RI,
    ST_F_ACC,
    ST_F_W,
    ST_DONE
  } state_t;

  // Sign-extend the low VALUE_BITS of a field
  function automatic logic signed [DATA_W-1:0] sx(input logic [DATA_W-1:0] v);
    logic [DATA_W-1:0] t;
    t = v << (DATA_W - VALUE_BITS);
    return $signed(t) >>> (DATA_W - VALUE_BITS);
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_sub(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? ACC_MIN : ACC_MAX;
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-DATA_W:0] top;
    top = v[PROD_W-1:DATA_W-1];
    if ((&top) || !(|top)) return v[DATA_W-1:0];
    return v[PROD_W-1] ? DATA_MIN : DATA_MAX;
  endfunction

  // Join high and low partial products, floor by FRAC_BITS, saturate
  function automatic logic signed [ACC_W-1:0] sat_scale(input logic signed [PROD_W-1:0] hi,
                                                        input logic signed [PROD_W-1:0] lo);
    logic signed [WIDE_W-1:0]           full;
    logic signed [WIDE_W-FRAC_BITS-1:0] v;
    logic [WIDE_W-FRAC_BITS-ACC_W:0]    top;
    full = $signed({hi, {DATA_W{1'b0}}}) + WIDE_W'(lo);
    v    = full[WIDE_W-1:FRAC_BITS];
    top  = v[WIDE_W-FRAC_BITS-1:ACC_W-1];
    if ((&top) || !(|top)) return v[ACC_W-1:0];
    return v[WIDE_W-FRAC_BITS-1] ? ACC_MIN : ACC_MAX;
  endfunction

endpackage

@@ design/hea_ram.sv @@
// ============================================================================
// hea_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module hea_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/hea_front.sv @@
// ============================================================================
// hea_front
// Accepts input words and the size register, checks index ranges and sorts
// each word into a command for the back end.
// ============================================================================
module hea_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          opcode,
  input  logic [4:0]          row,
  input  logic [4:0]          col,
  input  logic signed [31:0]  value_re,
  input  logic signed [31:0]  value_im,
  input  logic signed [31:0]  onsite_u,
  input  logic signed [31:0]  chem_pot,
  input  logic signed [31:0]  field_x,
  input  logic signed [31:0]  field_y,
  input  logic signed [31:0]  field_z,
  input  logic                q_full,
  output logic                q_push,
  output hea_pkg::cmd_t       q_cmd
);

  logic [4:0] sites_in_use;
  logic [5:0] l_cnt;
  logic [6:0] l7;
  logic [6:0] two_l;
  logic [6:0] r7;
  logic [6:0] c7;
  logic       hop_ok;
  logic       site_ok;
  logic       green_ok;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;

  // Size register
  always_ff @(posedge clk) begin
    if (rst) begin
      sites_in_use <= 5'd16;
    end else if (cfg_valid) begin
      sites_in_use <= cfg_data;
    end
  end

  // Clamp lattice size and form range checks
  always_comb begin
    if (sites_in_use == 5'd0) begin
      l_cnt = 6'd1;
    end else if (32'(sites_in_use) > hea_pkg::MAX_SITES) begin
      l_cnt = 6'(hea_pkg::MAX_SITES);
    end else begin
      l_cnt = {1'b0, sites_in_use};
    end
    l7       = {1'b0, l_cnt};
    two_l    = {l_cnt, 1'b0};
    r7       = {2'b00, row};
    c7       = {2'b00, col};
    hop_ok   = (32'(row) < hea_pkg::DIM) && (32'(col) < hea_pkg::DIM);
    site_ok  = 32'(row) < hea_pkg::MAX_SITES;
    green_ok = (r7 < two_l) && (c7 < two_l);
  end

  // Classify the word
  always_comb begin
    q_cmd           = '0;
    q_cmd.hop_addr  = hea_pkg::HOP_AW'(32'(row) * hea_pkg::DIM + 32'(col));
    q_cmd.site      = hea_pkg::SITE_AW'(row);
    q_cmd.value_re  = hea_pkg::sx(value_re);
    q_cmd.value_im  = hea_pkg::sx(value_im);
    q_cmd.onsite_u  = hea_pkg::sx(onsite_u);
    q_cmd.chem_pot  = hea_pkg::sx(chem_pot);
    q_cmd.field_x   = hea_pkg::sx(field_x);
    q_cmd.field_y   = hea_pkg::sx(field_y);
    q_cmd.field_z   = hea_pkg::sx(field_z);
    q_cmd.kind      = hea_pkg::CMD_NOP;
    case (opcode)
      hea_pkg::OP_LOAD_HOP: begin
        if (hop_ok) q_cmd.kind = hea_pkg::CMD_HOP;
      end
      hea_pkg::OP_LOAD_SITE: begin
        if (site_ok) q_cmd.kind = hea_pkg::CMD_SITE;
      end
      hea_pkg::OP_GREEN: begin
        if (green_ok) q_cmd.kind = hea_pkg::CMD_GREEN;
        // Diagonal and spin-flip elements feed the local and pair terms
        if (r7 == c7) begin
          q_cmd.local_hit = 1'b1;
          if (r7 < l7) begin
            q_cmd.site = hea_pkg::SITE_AW'(r7);
            q_cmd.slot = hea_pkg::SLOT_UU;
          end else begin
            q_cmd.site = hea_pkg::SITE_AW'(r7 - l7);
            q_cmd.slot = hea_pkg::SLOT_DD;
          end
        end else if (c7 == r7 + l7) begin
          q_cmd.local_hit = 1'b1;
          q_cmd.site      = hea_pkg::SITE_AW'(r7);
          q_cmd.slot      = hea_pkg::SLOT_UD;
        end else if (r7 == c7 + l7) begin
          q_cmd.local_hit = 1'b1;
          q_cmd.site      = hea_pkg::SITE_AW'(c7);
          q_cmd.slot      = hea_pkg::SLOT_DU;
        end
      end
      hea_pkg::OP_FINISH: q_cmd.kind = hea_pkg::CMD_FINISH;
      hea_pkg::OP_CLEAR:  q_cmd.kind = hea_pkg::CMD_CLEAR;
      default:            q_cmd.kind = hea_pkg::CMD_NOP;
    endcase
  end

endmodule

@@ design/hea_fifo.sv @@
// ============================================================================
// hea_fifo
// Short command queue that lets the front and back ends stall on their own.
// ============================================================================
module hea_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  hea_pkg::cmd_t din,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output hea_pkg::cmd_t dout
);

  hea_pkg::cmd_t               mem [hea_pkg::Q_DEPTH];
  logic [hea_pkg::Q_AW-1:0]    wr_ptr;
  logic [hea_pkg::Q_AW-1:0]    rd_ptr;
  logic [hea_pkg::Q_AW:0]      count;

  assign full  = count == (hea_pkg::Q_AW+1)'(hea_pkg::Q_DEPTH);
  assign valid = count != '0;
  assign dout  = mem[rd_ptr];

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ design/hea_cmul.sv @@
// ============================================================================
// hea_cmul
// Shared complex multiplier: four signed products, registered.
// ============================================================================
module hea_cmul (
  input  logic                                clk,
  input  logic signed [hea_pkg::MUL_W-1:0]    a_re,
  input  logic signed [hea_pkg::MUL_W-1:0]    a_im,
  input  logic signed [hea_pkg::MUL_W-1:0]    b_re,
  input  logic signed [hea_pkg::MUL_W-1:0]    b_im,
  output logic signed [hea_pkg::PROD_W-1:0]   p_rr,
  output logic signed [hea_pkg::PROD_W-1:0]   p_ii,
  output logic signed [hea_pkg::PROD_W-1:0]   p_ri,
  output logic signed [hea_pkg::PROD_W-1:0]   p_ir
);

  // Register every cross product
  always_ff @(posedge clk) begin
    p_rr <= a_re * b_re;
    p_ii <= a_im * b_im;
    p_ri <= a_re * b_im;
    p_ir <= a_im * b_re;
  end

endmodule

@@ design/hea_back.sv @@
// ============================================================================
// hea_back
// Executes commands: store loads, per-element kinetic, local and pair terms,
// weighted finish and total clearing; holds the result word for output.
// ============================================================================
module hea_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  hea_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [63:0]         total_energy_re,
  output logic signed [63:0]         total_energy_im,
  output logic signed [63:0]         total_kinetic_re,
  output logic signed [63:0]         total_kinetic_im,
  output logic signed [63:0]         total_interaction_re,
  output logic signed [63:0]         total_interaction_im,
  output logic signed [63:0]         total_local_re,
  output logic signed [63:0]         total_local_im,
  output logic signed [63:0]         total_weight_re,
  output logic signed [63:0]         total_weight_im
);

  localparam int DW = hea_pkg::DATA_W;
  localparam int AW = hea_pkg::ACC_W;
  localparam int PW = hea_pkg::PROD_W;
  localparam int MW = hea_pkg::MUL_W;
  localparam int S8 = hea_pkg::PROD_SHIFT;
  localparam int S9 = hea_pkg::PROD_SHIFT + 1;
  localparam int SF = hea_pkg::FRAC_BITS;

  hea_pkg::state_t state, state_next;
  hea_pkg::cmd_t   cmd;

  // Multiplier
  logic signed [MW-1:0] mul_a_re, mul_a_im, mul_b_re, mul_b_im;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;

  // Stores
  logic                         hop_we, hop_re;
  logic [2*DW-1:0]              hop_rdata;
  logic                         site_we, site_re;
  logic [hea_pkg::SITE_W-1:0]   site_wdata, site_rdata;
  logic                         part_we, part_re;
  logic [hea_pkg::PART_AW-1:0]  part_waddr, part_raddr;
  logic [2*DW-1:0]              part_rdata;
  logic [hea_pkg::PART_DEPTH-1:0] part_flags;

  // Sample sums and totals
  logic signed [AW-1:0] kin_re, kin_im, int_re, int_im, loc_re, loc_im;
  logic signed [AW-1:0] tot [10];
  logic [1:0]           widx;

  // Finish datapath
  logic signed [AW-1:0] h_re, h_im, src_re, src_im;
  logic signed [PW-1:0] lo_rr, lo_ii, lo_ri, lo_ir;
  logic signed [AW-1:0] m_rr, m_ii, m_ri, m_ir;
  logic signed [AW-1:0] w_re, w_im;
  logic signed [DW-1:0] pr_q, pi_q;

  // Green datapath
  logic signed [PW-1:0] k_re_d, k_im_d, l_re_d, l_im_d, pr_d, pi_d;
  logic signed [DW-1:0] s_u, s_mu, s_hx, s_hy, s_hz;
  logic                 partner_ok;
  logic                 out_free;

  assign s_u  = site_rdata[5*DW-1:4*DW];
  assign s_mu = site_rdata[4*DW-1:3*DW];
  assign s_hx = site_rdata[3*DW-1:2*DW];
  assign s_hy = site_rdata[2*DW-1:DW];
  assign s_hz = site_rdata[DW-1:0];

  assign site_wdata = {cmd.onsite_u, cmd.chem_pot, cmd.field_x, cmd.field_y, cmd.field_z};
  assign part_waddr = {cmd.site, cmd.slot};
  assign part_raddr = {cmd.site, cmd.slot ^ 2'b01};
  assign partner_ok = part_flags[part_raddr];
  assign out_free   = !out_valid || out_ready;

  hea_cmul u_cmul (
    .clk  (clk),
    .a_re (mul_a_re),
    .a_im (mul_a_im),
    .b_re (mul_b_re),
    .b_im (mul_b_im),
    .p_rr (p_rr),
    .p_ii (p_ii),
    .p_ri (p_ri),
    .p_ir (p_ir)
  );

  hea_ram #(.WIDTH(2 * DW), .DEPTH(hea_pkg::HOP_DEPTH)) u_hop_ram (
    .clk   (clk),
    .we    (hop_we),
    .waddr (cmd.hop_addr),
    .wdata ({cmd.value_re, cmd.value_im}),
    .re    (hop_re),
    .raddr (cmd.hop_addr),
    .rdata (hop_rdata)
  );

  hea_ram #(.WIDTH(hea_pkg::SITE_W), .DEPTH(hea_pkg::MAX_SITES)) u_site_ram (
    .clk   (clk),
    .we    (site_we),
    .waddr (cmd.site),
    .wdata (site_wdata),
    .re    (site_re),
    .raddr (cmd.site),
    .rdata (site_rdata)
  );

  hea_ram #(.WIDTH(2 * DW), .DEPTH(hea_pkg::PART_DEPTH)) u_part_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (part_waddr),
    .wdata ({cmd.value_re, cmd.value_im}),
    .re    (part_re),
    .raddr (part_raddr),
    .rdata (part_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      hea_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            hea_pkg::CMD_GREEN:  state_next = hea_pkg::ST_G_READ;
            hea_pkg::CMD_FINISH: state_next = hea_pkg::ST_F_H1;
            default:             state_next = hea_pkg::ST_EXEC;
          endcase
        end
      end
      hea_pkg::ST_EXEC:   state_next = hea_pkg::ST_DONE;
      hea_pkg::ST_G_READ: state_next = hea_pkg::ST_G_KIN;
      hea_pkg::ST_G_KIN:  state_next = hea_pkg::ST_G_KACC;
      hea_pkg::ST_G_KACC: state_next = cmd.local_hit ? hea_pkg::ST_G_LACC : hea_pkg::ST_DONE;
      hea_pkg::ST_G_LACC: state_next = partner_ok ? hea_pkg::ST_G_PSAT : hea_pkg::ST_DONE;
      hea_pkg::ST_G_PSAT: state_next = hea_pkg::ST_G_U;
      hea_pkg::ST_G_U:    state_next = hea_pkg::ST_G_IACC;
      hea_pkg::ST_G_IACC: state_next = hea_pkg::ST_DONE;
      hea_pkg::ST_F_H1:   state_next = hea_pkg::ST_F_H2;
      hea_pkg::ST_F_H2:   state_next = hea_pkg::ST_F_LO;
      hea_pkg::ST_F_LO:   state_next = hea_pkg::ST_F_HI;
      hea_pkg::ST_F_HI:   state_next = hea_pkg::ST_F_COMB;
      hea_pkg::ST_F_COMB: state_next = hea_pkg::ST_F_RI;
      hea_pkg::ST_F_RI:   state_next = hea_pkg::ST_F_ACC;
      hea_pkg::ST_F_ACC:  state_next = (widx == 2'd3) ? hea_pkg::ST_F_W : hea_pkg::ST_F_LO;
      hea_pkg::ST_F_W:    state_next = hea_pkg::ST_DONE;
      hea_pkg::ST_DONE:   state_next = out_free ? hea_pkg::ST_IDLE : hea_pkg::ST_DONE;
      default:            state_next = hea_pkg::ST_IDLE;
    endcase
  end

  // Pick the sum being weighted
  always_comb begin
    case (widx)
      2'd0:    begin src_re = h_re;   src_im = h_im;   end
      2'd1:    begin src_re = kin_re; src_im = kin_im; end
      2'd2:    begin src_re = int_re; src_im = int_im; end
      default: begin src_re = loc_re; src_im = loc_im; end
    endcase
  end

  // Outputs: store strobes, queue pop and multiplier operands
  always_comb begin
    q_pop    = 1'b0;
    hop_we   = 1'b0;
    hop_re   = 1'b0;
    site_we  = 1'b0;
    site_re  = 1'b0;
    part_we  = 1'b0;
    part_re  = 1'b0;
    mul_a_re = '0;
    mul_a_im = '0;
    mul_b_re = MW'(cmd.value_re);
    mul_b_im = MW'(cmd.value_im);
    case (state)
      hea_pkg::ST_IDLE: q_pop = q_valid;
      hea_pkg::ST_EXEC: begin
        hop_we  = cmd.kind == hea_pkg::CMD_HOP;
        site_we = cmd.kind == hea_pkg::CMD_SITE;
      end
      hea_pkg::ST_G_READ: begin
        hop_re  = 1'b1;
        site_re = 1'b1;
        part_re = 1'b1;
      end
      hea_pkg::ST_G_KIN: begin
        mul_a_re = MW'($signed(hop_rdata[2*DW-1:DW]));
        mul_a_im = MW'($signed(hop_rdata[DW-1:0]));
      end
      hea_pkg::ST_G_KACC: begin
        if (cmd.slot[1]) begin
          mul_a_re = MW'(s_hx);
          mul_a_im = MW'(s_hy);
        end else begin
          mul_a_re = MW'(s_hz);
          mul_a_im = MW'(s_mu);
        end
      end
      hea_pkg::ST_G_LACC: begin
        part_we  = 1'b1;
        mul_a_re = MW'(cmd.value_re);
        mul_a_im = MW'(cmd.value_im);
        mul_b_re = MW'($signed(part_rdata[2*DW-1:DW]));
        mul_b_im = MW'($signed(part_rdata[DW-1:0]));
      end
      hea_pkg::ST_G_U: begin
        mul_a_re = MW'(s_u);
        mul_b_re = MW'(pr_q);
        mul_b_im = MW'(pi_q);
      end
      hea_pkg::ST_F_LO: begin
        mul_a_re = {1'b0, src_re[DW-1:0]};
        mul_a_im = {1'b0, src_im[DW-1:0]};
      end
      hea_pkg::ST_F_HI: begin
        mul_a_re = MW'($signed(src_re[AW-1:DW]));
        mul_a_im = MW'($signed(src_im[AW-1:DW]));
      end
      default: begin
        mul_a_re = '0;
      end
    endcase
  end

  // Combine products for the green element terms
  always_comb begin
    k_re_d = (p_rr >>> S8) - (p_ii >>> S8);
    k_im_d = (p_ri >>> S8) + (p_ir >>> S8);
    case (cmd.slot)
      hea_pkg::SLOT_UU: begin
        l_re_d = (p_rr >>> S9) - (p_ir >>> S8);
        l_im_d = (p_ri >>> S9) - (p_ii >>> S8);
      end
      hea_pkg::SLOT_DD: begin
        l_re_d = -(p_ir >>> S8) - (p_rr >>> S9);
        l_im_d = -(p_ii >>> S8) - (p_ri >>> S9);
      end
      hea_pkg::SLOT_UD: begin
        l_re_d = (p_rr >>> S9) + (p_ii >>> S9);
        l_im_d = (p_ri >>> S9) - (p_ir >>> S9);
      end
      default: begin
        l_re_d = (p_rr >>> S9) - (p_ii >>> S9);
        l_im_d = (p_ri >>> S9) + (p_ir >>> S9);
      end
    endcase
    pr_d = (p_rr >>> SF) - (p_ii >>> SF);
    pi_d = (p_ri >>> SF) + (p_ir >>> SF);
  end

  // Control state, sample sums and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hea_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      part_flags <= '0;
      kin_re     <= '0;
      kin_im     <= '0;
      int_re     <= '0;
      int_im     <= '0;
      loc_re     <= '0;
      loc_im     <= '0;
      widx       <= '0;
      for (int i = 0; i < 10; i++) tot[i] <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        hea_pkg::ST_EXEC: begin
          if (cmd.kind == hea_pkg::CMD_CLEAR) begin
            for (int i = 0; i < 10; i++) tot[i] <= '0;
          end
        end
        hea_pkg::ST_G_KACC: begin
          kin_re <= hea_pkg::sat_add(kin_re, k_re_d[AW-1:0]);
          kin_im <= hea_pkg::sat_add(kin_im, k_im_d[AW-1:0]);
        end
        hea_pkg::ST_G_LACC: begin
          loc_re <= hea_pkg::sat_add(loc_re, l_re_d[AW-1:0]);
          loc_im <= hea_pkg::sat_add(loc_im, l_im_d[AW-1:0]);
          part_flags[part_waddr] <= 1'b1;
        end
        hea_pkg::ST_G_IACC: begin
          // Spin-flip pairs enter with a minus sign
          if (cmd.slot[1]) begin
            int_re <= hea_pkg::sat_sub(int_re, AW'(p_rr >>> S8));
            int_im <= hea_pkg::sat_sub(int_im, AW'(p_ri >>> S8));
          end else begin
            int_re <= hea_pkg::sat_add(int_re, AW'(p_rr >>> S8));
            int_im <= hea_pkg::sat_add(int_im, AW'(p_ri >>> S8));
          end
        end
        hea_pkg::ST_F_H2: widx <= '0;
        hea_pkg::ST_F_ACC: begin
          widx <= widx + 2'd1;
          case (widx)
            2'd0: begin
              tot[0] <= hea_pkg::sat_add(tot[0], w_re);
              tot[1] <= hea_pkg::sat_add(tot[1], w_im);
            end
            2'd1: begin
              tot[2] <= hea_pkg::sat_add(tot[2], w_re);
              tot[3] <= hea_pkg::sat_add(tot[3], w_im);
            end
            2'd2: begin
              tot[4] <= hea_pkg::sat_add(tot[4], w_re);
              tot[5] <= hea_pkg::sat_add(tot[5], w_im);
            end
            default: begin
              tot[6] <= hea_pkg::sat_add(tot[6], w_re);
              tot[7] <= hea_pkg::sat_add(tot[7], w_im);
            end
          endcase
        end
        hea_pkg::ST_F_W: begin
          tot[8] <= hea_pkg::sat_add(tot[8], AW'(cmd.value_re) <<< hea_pkg::WEIGHT_SHIFT);
          tot[9] <= hea_pkg::sat_add(tot[9], AW'(cmd.value_im) <<< hea_pkg::WEIGHT_SHIFT);
          part_flags <= '0;
          kin_re     <= '0;
          kin_im     <= '0;
          int_re     <= '0;
          int_im     <= '0;
          loc_re     <= '0;
          loc_im     <= '0;
        end
        hea_pkg::ST_DONE: begin
          if (out_free) out_valid <= 1'b1;
        end
        default: begin
          widx <= widx;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == hea_pkg::ST_IDLE && q_valid) cmd <= q_cmd;
    if (state == hea_pkg::ST_G_PSAT) begin
      pr_q <= hea_pkg::sat32(pr_d);
      pi_q <= hea_pkg::sat32(pi_d);
    end
    if (state == hea_pkg::ST_F_H1) begin
      h_re <= hea_pkg::sat_add(kin_re, int_re);
      h_im <= hea_pkg::sat_add(kin_im, int_im);
    end
    if (state == hea_pkg::ST_F_H2) begin
      h_re <= hea_pkg::sat_add(h_re, loc_re);
      h_im <= hea_pkg::sat_add(h_im, loc_im);
    end
    if (state == hea_pkg::ST_F_HI) begin
      lo_rr <= p_rr;
      lo_ii <= p_ii;
      lo_ri <= p_ri;
      lo_ir <= p_ir;
    end
    if (state == hea_pkg::ST_F_COMB) begin
      m_rr <= hea_pkg::sat_scale(p_rr, lo_rr);
      m_ii <= hea_pkg::sat_scale(p_ii, lo_ii);
      m_ri <= hea_pkg::sat_scale(p_ri, lo_ri);
      m_ir <= hea_pkg::sat_scale(p_ir, lo_ir);
    end
    if (state == hea_pkg::ST_F_RI) begin
      w_re <= hea_pkg::sat_sub(m_rr, m_ii);
      w_im <= hea_pkg::sat_add(m_ri, m_ir);
    end
    // Capture the result word
    if (state == hea_pkg::ST_DONE && out_free) begin
      total_energy_re      <= tot[0];
      total_energy_im      <= tot[1];
      total_kinetic_re     <= tot[2];
      total_kinetic_im     <= tot[3];
      total_interaction_re <= tot[4];
      total_interaction_im <= tot[5];
      total_local_re       <= tot[6];
      total_local_im       <= tot[7];
      total_weight_re      <= tot[8];
      total_weight_im      <= tot[9];
    end
  end

endmodule

@@ design/soc_hubbard_energy_accumulator.sv @@
// Each accepted input word passes through the two-word queue to the back-end sequencer, which
// takes separate state paths for loads, clears and ignored words, for a Green element with a
// kinetic term only, with a local term or with a pair product, and for a finish, all around
// its one shared complex multiplier. It completes one word before it pops the next; the queue
// and an output register let the ends stall independently.
// Synchronous reset clears totals, sample sums and partial flags; stores keep data.
// ============================================================================
// soc_hubbard_energy_accumulator
// Top level: front classifier, command queue and back-end executor.
// ============================================================================
module soc_hubbard_energy_accumulator (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          opcode,
  input  logic [4:0]          row,
  input  logic [4:0]          col,
  input  logic signed [31:0]  value_re,
  input  logic signed [31:0]  value_im,
  input  logic signed [31:0]  onsite_u,
  input  logic signed [31:0]  chem_pot,
  input  logic signed [31:0]  field_x,
  input  logic signed [31:0]  field_y,
  input  logic signed [31:0]  field_z,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  total_energy_re,
  output logic signed [63:0]  total_energy_im,
  output logic signed [63:0]  total_kinetic_re,
  output logic signed [63:0]  total_kinetic_im,
  output logic signed [63:0]  total_interaction_re,
  output logic signed [63:0]  total_interaction_im,
  output logic signed [63:0]  total_local_re,
  output logic signed [63:0]  total_local_im,
  output logic signed [63:0]  total_weight_re,
  output logic signed [63:0]  total_weight_im
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  hea_pkg::cmd_t q_in;
  hea_pkg::cmd_t q_out;

  hea_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .row       (row),
    .col       (col),
    .value_re  (value_re),
    .value_im  (value_im),
    .onsite_u  (onsite_u),
    .chem_pot  (chem_pot),
    .field_x   (field_x),
    .field_y   (field_y),
    .field_z   (field_z),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_in)
  );

  hea_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_in),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_out)
  );

  hea_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .q_valid              (q_valid),
    .q_cmd                (q_out),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .total_energy_re      (total_energy_re),
    .total_energy_im      (total_energy_im),
    .total_kinetic_re     (total_kinetic_re),
    .total_kinetic_im     (total_kinetic_im),
    .total_interaction_re (total_interaction_re),
    .total_interaction_im (total_interaction_im),
    .total_local_re       (total_local_re),
    .total_local_im       (total_local_im),
    .total_weight_re      (total_weight_re),
    .total_weight_im      (total_weight_im)
  );

endmodule
